// File: src/atsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atsm_pkg
// Shared types and constants for the terminal screen block.
// ----------------------------------------------------------------------------
package atsm_pkg;

  localparam int SCREEN_ROWS_DEF = 24;
  localparam int SCREEN_COLS_DEF = 512;
  localparam int MAX_PARAMS_DEF  = 4;

  localparam logic [1:0] MODE_FEED   = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_MID_LAST = 8'h3f;
  localparam logic [7:0] CH_LBR   = 8'h5b;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_J     = 8'h4a;
  localparam logic [7:0] CH_K     = 8'h4b;

  localparam logic [15:0] PARAM_MAX = 16'hffff;

  typedef enum logic [1:0] {
    OP_FEED,
    OP_READ,
    OP_CLEAR,
    OP_NOP
  } op_t;

  // Meaning of a byte outside a control sequence.
  typedef enum logic [2:0] {
    BC_ESC,
    BC_CR,
    BC_LF,
    BC_BS,
    BC_IGNORE,
    BC_PRINT
  } byte_class_t;

  // Meaning of a byte inside a control sequence.
  typedef enum logic [1:0] {
    CC_DIGIT,
    CC_SEMI,
    CC_MID,
    CC_FINAL
  } csi_class_t;

  typedef enum logic [1:0] {
    PH_GROUND,
    PH_ESC,
    PH_CSI
  } phase_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_SWEEP
  } bk_state_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] in_byte;
    logic [4:0] read_row;
    logic [8:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  cell_char;
    logic [15:0] cursor_row;
    logic [15:0] cursor_col;
  } out_item_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  code;
    byte_class_t bclass;
    csi_class_t  cclass;
    logic        is_lbr;
    logic [4:0]  read_row;
    logic [8:0]  read_col;
  } cmd_t;

endpackage
`default_nettype wire

// File: src/ansi_terminal_screen_model.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ansi_terminal_screen_model
// Character screen driven by a terminal byte stream with a small CSI parser.
// ----------------------------------------------------------------------------
// Usage:
//   The feed channel carries one word per step: mode 0 feeds a terminal byte,
//   mode 1 reads the cell at (read_row, read_col), mode 2 clears the screen
//   and homes the cursor. Every accepted word yields exactly one result word
//   on the result channel with the cell (reads only) and the cursor after it.
//   A two-entry queue sits between the classifying front and the executing
//   back, so the feed side keeps accepting while a result waits.
//   A byte or cursor command gives its result in the cycle after the back
//   takes it; a read first passes the registered screen memory read port.
//   Throughput: one byte per cycle for printable bytes and cursor moves
//   while result_ready stays high; erases write one cleared cell at a time
//   through the single memory write port, SCREEN_ROWS*SCREEN_COLS cells for
//   a full clear, up to SCREEN_COLS cells for an erase line.
//   Reset: after rst the back sweeps spaces into all SCREEN_ROWS*SCREEN_COLS
//   cells (12288 by default) before it takes any word; the queue may
//   fill meanwhile.
//   A stalled result holds the back, the queue fills, then feed_ready drops.
// ----------------------------------------------------------------------------
module ansi_terminal_screen_model #(
  parameter int SCREEN_ROWS = atsm_pkg::SCREEN_ROWS_DEF,
  parameter int SCREEN_COLS = atsm_pkg::SCREEN_COLS_DEF,
  parameter int MAX_PARAMS  = atsm_pkg::MAX_PARAMS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 feed_valid,
  output logic                feed_ready,
  input  atsm_pkg::in_item_t  feed_item,
  output logic                result_valid,
  input  wire                 result_ready,
  output atsm_pkg::out_item_t result_item
);

  // Classified commands waiting for the back.
  logic           cmd_valid;
  logic           cmd_pop;
  atsm_pkg::cmd_t cmd;

  atsm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .feed_valid (feed_valid),
    .feed_ready (feed_ready),
    .feed_item  (feed_item),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  // The back owns the parser state, the cursor and the screen memory.
  atsm_back #(
    .SCREEN_ROWS (SCREEN_ROWS),
    .SCREEN_COLS (SCREEN_COLS),
    .MAX_PARAMS  (MAX_PARAMS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

endmodule
`default_nettype wire

// File: src/atsm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atsm_front
// Accepts input words, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module atsm_front (
  input  wire               clk,
  input  wire               rst,
  input  wire               feed_valid,
  output logic              feed_ready,
  input  atsm_pkg::in_item_t feed_item,
  output logic              cmd_valid,
  output atsm_pkg::cmd_t    cmd,
  input  wire               cmd_pop
);

  atsm_pkg::cmd_t q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  atsm_pkg::cmd_t entry;
  logic       push;

  always_comb begin
    entry.code     = feed_item.in_byte;
    entry.read_row = feed_item.read_row;
    entry.read_col = feed_item.read_col;
    case (feed_item.mode)
      atsm_pkg::MODE_FEED:  entry.op = atsm_pkg::OP_FEED;
      atsm_pkg::MODE_READ:  entry.op = atsm_pkg::OP_READ;
      atsm_pkg::MODE_CLEAR: entry.op = atsm_pkg::OP_CLEAR;
      default:              entry.op = atsm_pkg::OP_NOP;
    endcase
    if (feed_item.in_byte == atsm_pkg::CH_ESC) begin
      entry.bclass = atsm_pkg::BC_ESC;
    end else if (feed_item.in_byte == atsm_pkg::CH_CR) begin
      entry.bclass = atsm_pkg::BC_CR;
    end else if (feed_item.in_byte == atsm_pkg::CH_LF) begin
      entry.bclass = atsm_pkg::BC_LF;
    end else if (feed_item.in_byte == atsm_pkg::CH_BS) begin
      entry.bclass = atsm_pkg::BC_BS;
    end else if (feed_item.in_byte < atsm_pkg::CH_SPACE &&
                 feed_item.in_byte != atsm_pkg::CH_TAB) begin
      entry.bclass = atsm_pkg::BC_IGNORE;
    end else begin
      entry.bclass = atsm_pkg::BC_PRINT;
    end
    if (feed_item.in_byte inside {[atsm_pkg::CH_ZERO:atsm_pkg::CH_NINE]}) begin
      entry.cclass = atsm_pkg::CC_DIGIT;
    end else if (feed_item.in_byte == atsm_pkg::CH_SEMI) begin
      entry.cclass = atsm_pkg::CC_SEMI;
    end else if (feed_item.in_byte inside {[atsm_pkg::CH_SPACE:atsm_pkg::CH_MID_LAST]}) begin
      entry.cclass = atsm_pkg::CC_MID;
    end else begin
      entry.cclass = atsm_pkg::CC_FINAL;
    end
    entry.is_lbr = (feed_item.in_byte == atsm_pkg::CH_LBR);
  end

  assign feed_ready = (count != 2'd2);
  assign push       = feed_valid && feed_ready;
  assign cmd_valid  = (count != 2'd0);
  assign cmd        = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= entry;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

endmodule
`default_nettype wire

// File: src/atsm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atsm_back
// Parser, cursor, screen memory, erase sweep and result register.
// ----------------------------------------------------------------------------
module atsm_back #(
  parameter int SCREEN_ROWS = atsm_pkg::SCREEN_ROWS_DEF,
  parameter int SCREEN_COLS = atsm_pkg::SCREEN_COLS_DEF,
  parameter int MAX_PARAMS  = atsm_pkg::MAX_PARAMS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cmd_valid,
  input  atsm_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  output logic                result_valid,
  input  wire                 result_ready,
  output atsm_pkg::out_item_t result_item
);

  localparam int TOTAL = SCREEN_ROWS * SCREEN_COLS;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int SW    = $clog2(TOTAL + 1);
  localparam int PCW   = $clog2(MAX_PARAMS + 1);
  localparam int PIW   = $clog2(MAX_PARAMS);

  logic [7:0] mem [TOTAL];
  logic [7:0] rdata;
  logic       read_ok;

  atsm_pkg::bk_state_t state, state_next;
  atsm_pkg::phase_t    phase, phase_next;
  logic [15:0]    params [MAX_PARAMS];
  logic [15:0]    params_next [MAX_PARAMS];
  logic [PCW-1:0] pcount, pcount_next;
  logic           digit_seen, digit_seen_next;
  logic           private_mark, private_mark_next;
  logic [15:0]    row_pos, row_pos_next;
  logic [15:0]    col_pos, col_pos_next;
  logic [SW-1:0]  sweep_addr, sweep_addr_next;
  logic [SW-1:0]  sweep_end, sweep_end_next;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [7:0]     mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  logic           read_ok_next;
  logic           emit_now;
  logic           go_sweep;
  logic           sweep_last;

  assign cmd_pop = (state == atsm_pkg::BK_IDLE) && cmd_valid &&
                   (!result_valid || result_ready);
  assign sweep_last = (sweep_addr + SW'(1) == sweep_end);

  always_comb begin
    logic           in_screen;
    logic [SW-1:0]  base;
    logic [SW-1:0]  col_clamp;
    logic [SW-1:0]  s_start;
    logic [SW-1:0]  s_end;
    logic           want_sweep;
    logic           ground;
    logic [PIW-1:0] idx;
    logic [19:0]    acc;
    logic [PCW-1:0] cnt2;
    logic [15:0]    p0;
    logic [15:0]    p1;
    in_screen = (row_pos < 16'(SCREEN_ROWS)) && (col_pos < 16'(SCREEN_COLS));
    base      = SW'(row_pos) * SW'(SCREEN_COLS);
    col_clamp = (col_pos < 16'(SCREEN_COLS)) ? SW'(col_pos) : SW'(SCREEN_COLS);
    s_start    = '0;
    s_end      = '0;
    want_sweep = 1'b0;
    ground     = 1'b0;
    idx        = pcount[PIW-1:0];
    acc        = {1'b0, params[idx], 3'b0} + {3'b0, params[idx], 1'b0} +
                 {16'b0, cmd.code[3:0]};
    cnt2       = pcount + {{(PCW-1){1'b0}}, (digit_seen && pcount < PCW'(MAX_PARAMS))};
    p0         = params[0];
    p1         = params[1];

    phase_next        = phase;
    params_next       = params;
    pcount_next       = pcount;
    digit_seen_next   = digit_seen;
    private_mark_next = private_mark;
    row_pos_next      = row_pos;
    col_pos_next      = col_pos;
    sweep_addr_next   = sweep_addr;
    sweep_end_next    = sweep_end;
    mem_we    = 1'b0;
    mem_waddr = sweep_addr[AW-1:0];
    mem_wdata = atsm_pkg::CH_SPACE;
    mem_re    = 1'b0;
    mem_raddr = AW'(SW'(cmd.read_row) * SW'(SCREEN_COLS) + SW'(cmd.read_col));
    read_ok_next = (32'(cmd.read_row) < SCREEN_ROWS) && (32'(cmd.read_col) < SCREEN_COLS);
    emit_now = 1'b0;
    go_sweep = 1'b0;

    if (state == atsm_pkg::BK_CLEAR || state == atsm_pkg::BK_SWEEP) begin
      mem_we          = 1'b1;
      sweep_addr_next = sweep_addr + SW'(1);
    end else if (cmd_pop) begin
      case (cmd.op)
        atsm_pkg::OP_FEED: begin
          case (phase)
            atsm_pkg::PH_ESC: begin
              if (cmd.is_lbr) begin
                for (int i = 0; i < MAX_PARAMS; i++) begin
                  params_next[i] = '0;
                end
                pcount_next       = '0;
                digit_seen_next   = 1'b0;
                private_mark_next = 1'b0;
                phase_next        = atsm_pkg::PH_CSI;
              end else begin
                phase_next = atsm_pkg::PH_GROUND;
                ground     = 1'b1;
              end
            end
            atsm_pkg::PH_CSI: begin
              case (cmd.cclass)
                atsm_pkg::CC_DIGIT: begin
                  if (pcount < PCW'(MAX_PARAMS)) begin
                    params_next[idx] = (acc > 20'(atsm_pkg::PARAM_MAX)) ?
                                       atsm_pkg::PARAM_MAX : acc[15:0];
                  end
                  digit_seen_next = 1'b1;
                end
                atsm_pkg::CC_SEMI: begin
                  pcount_next     = cnt2;
                  digit_seen_next = 1'b0;
                end
                atsm_pkg::CC_MID: begin
                  private_mark_next = 1'b1;
                end
                default: begin
                  phase_next = atsm_pkg::PH_GROUND;
                  if (!private_mark) begin
                    pcount_next = cnt2;
                    if (cmd.code == atsm_pkg::CH_H) begin
                      row_pos_next = (cnt2 >= PCW'(1) && p0 != 16'd0) ? p0 - 16'd1 : 16'd0;
                      col_pos_next = (cnt2 >= PCW'(2) && p1 != 16'd0) ? p1 - 16'd1 : 16'd0;
                    end else if (cmd.code == atsm_pkg::CH_J) begin
                      if (cnt2 >= PCW'(1) && p0 == 16'd2) begin
                        want_sweep = 1'b1;
                        s_start    = '0;
                        s_end      = SW'(TOTAL);
                      end else if (cnt2 == '0 || p0 == 16'd0) begin
                        want_sweep = (row_pos < 16'(SCREEN_ROWS));
                        s_start    = base + col_clamp;
                        s_end      = SW'(TOTAL);
                      end
                    end else if (cmd.code == atsm_pkg::CH_K) begin
                      want_sweep = in_screen;
                      s_start    = base + col_clamp;
                      s_end      = base + SW'(SCREEN_COLS);
                    end
                  end
                end
              endcase
            end
            default: begin
              ground = 1'b1;
            end
          endcase
          if (ground) begin
            case (cmd.bclass)
              atsm_pkg::BC_ESC: phase_next = atsm_pkg::PH_ESC;
              atsm_pkg::BC_CR:  col_pos_next = 16'd0;
              atsm_pkg::BC_LF: begin
                if (17'(row_pos) + 17'd1 < 17'(SCREEN_ROWS)) begin
                  row_pos_next = row_pos + 16'd1;
                end
              end
              atsm_pkg::BC_BS: begin
                if (col_pos != 16'd0) begin
                  col_pos_next = col_pos - 16'd1;
                end
              end
              atsm_pkg::BC_PRINT: begin
                if (in_screen) begin
                  mem_we       = 1'b1;
                  mem_waddr    = AW'(base + SW'(col_pos));
                  mem_wdata    = cmd.code;
                  col_pos_next = col_pos + 16'd1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        atsm_pkg::OP_READ: begin
          mem_re = 1'b1;
        end
        atsm_pkg::OP_CLEAR: begin
          row_pos_next = 16'd0;
          col_pos_next = 16'd0;
          want_sweep   = 1'b1;
          s_start      = '0;
          s_end        = SW'(TOTAL);
        end
        default: begin
        end
      endcase
      if (want_sweep && s_start < s_end) begin
        go_sweep        = 1'b1;
        sweep_addr_next = s_start;
        sweep_end_next  = s_end;
      end else if (cmd.op != atsm_pkg::OP_READ) begin
        emit_now = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      atsm_pkg::BK_CLEAR: begin
        if (sweep_last) begin
          state_next = atsm_pkg::BK_IDLE;
        end
      end
      atsm_pkg::BK_IDLE: begin
        if (go_sweep) begin
          state_next = atsm_pkg::BK_SWEEP;
        end else if (mem_re) begin
          state_next = atsm_pkg::BK_READ;
        end
      end
      atsm_pkg::BK_READ: state_next = atsm_pkg::BK_IDLE;
      atsm_pkg::BK_SWEEP: begin
        if (sweep_last) begin
          state_next = atsm_pkg::BK_IDLE;
        end
      end
      default: state_next = atsm_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata   <= mem[mem_raddr];
      read_ok <= read_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) begin
      result_item <= '{cell_char: 8'h00, cursor_row: row_pos_next, cursor_col: col_pos_next};
    end else if (state == atsm_pkg::BK_READ) begin
      result_item <= '{cell_char: (read_ok ? rdata : 8'h00),
                       cursor_row: row_pos, cursor_col: col_pos};
    end else if (state == atsm_pkg::BK_SWEEP && sweep_last) begin
      result_item <= '{cell_char: 8'h00, cursor_row: row_pos, cursor_col: col_pos};
    end
    if (rst) begin
      state        <= atsm_pkg::BK_CLEAR;
      phase        <= atsm_pkg::PH_GROUND;
      for (int i = 0; i < MAX_PARAMS; i++) begin
        params[i] <= '0;
      end
      pcount       <= '0;
      digit_seen   <= 1'b0;
      private_mark <= 1'b0;
      row_pos      <= 16'd0;
      col_pos      <= 16'd0;
      sweep_addr   <= '0;
      sweep_end    <= SW'(TOTAL);
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      phase        <= phase_next;
      params       <= params_next;
      pcount       <= pcount_next;
      digit_seen   <= digit_seen_next;
      private_mark <= private_mark_next;
      row_pos      <= row_pos_next;
      col_pos      <= col_pos_next;
      sweep_addr   <= sweep_addr_next;
      sweep_end    <= sweep_end_next;
      if (emit_now || state == atsm_pkg::BK_READ ||
          (state == atsm_pkg::BK_SWEEP && sweep_last)) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == atsm_pkg::BK_CLEAR) |-> !cmd_pop)
    else $error("command taken during clearing pass");

  a_sweep_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == atsm_pkg::BK_SWEEP || state == atsm_pkg::BK_CLEAR) |-> (sweep_addr < sweep_end))
    else $error("sweep address past its end");

  a_read_follows_pop: assert property (@(posedge clk) disable iff (rst)
    (cmd_pop && cmd.op == atsm_pkg::OP_READ) |=> (state == atsm_pkg::BK_READ))
    else $error("read did not enter read state");

  a_read_gives_result: assert property (@(posedge clk) disable iff (rst)
    (state == atsm_pkg::BK_READ) |=> result_valid)
    else $error("read produced no result");

endmodule
`default_nettype wire
